// ===== hdl/sspc_pkg.sv =====
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared types, codes and helpers for the stepper speed/position controller.
// ----------------------------------------------------------------------------
package sspc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIV_W     = 64;
  localparam int DSR_W     = 33;
  localparam int DCNT_W    = $clog2(DIV_W + 1);
  localparam int OUT_W     = 104;

  localparam logic [2:0] REQ_STEP    = 3'd0;
  localparam logic [2:0] REQ_SETSPD  = 3'd1;
  localparam logic [2:0] REQ_SETPOS  = 3'd2;
  localparam logic [2:0] REQ_MEAS    = 3'd3;
  localparam logic [2:0] REQ_INIT    = 3'd4;
  localparam logic [2:0] REQ_RESET   = 3'd5;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  localparam logic [2:0] CFG_MIN_POS   = 3'd0;
  localparam logic [2:0] CFG_MAX_POS   = 3'd1;
  localparam logic [2:0] CFG_MIN_SPD   = 3'd2;
  localparam logic [2:0] CFG_MAX_SPD   = 3'd3;
  localparam logic [2:0] CFG_STEP_SIZE = 3'd4;
  localparam logic [2:0] CFG_WRAP_EN   = 3'd5;
  localparam logic [2:0] CFG_START_POS = 3'd6;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_STEP, OP_RESET, OP_SETSPD, OP_BAD,
    OP_PMUL, OP_PSAT, OP_PDIV_GO, OP_PFIX, OP_RDIV_GO, OP_RFIX,
    OP_SPD, OP_FFIX, OP_INIT, OP_IWDIV_GO, OP_IWFIX, OP_IDIV_GO,
    OP_IFIX, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_INIT_CHK, ST_PMUL, ST_PWRAP, ST_PDIV, ST_PRE,
    ST_RDIV, ST_SPD, ST_FDIV, ST_IWDIV, ST_IDIV_GO, ST_IDIV, ST_OUT
  } ctrl_st_t;

  typedef struct packed {
    logic [2:0] req;
    logic       dt_zero;
    logic       ss_zero;
    logic       wrap_en;
    logic       range_bad;
    logic       spd_stop;
    logic       div_done;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [31:0] sat_q(input logic [63:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (|q[63:31]) ? 32'h8000_0000 : 32'(-q[31:0]);
    end else begin
      r = (|q[63:31]) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/sspc_div.sv =====
// ----------------------------------------------------------------------------
// sspc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sspc_div import sspc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic [DIV_W-1:0] quo,
  output logic [DSR_W-1:0] rem,
  output logic             busy,
  output logic             done
);

  logic [DIV_W-1:0]  q_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DSR_W:0]    shifted;
  logic [DSR_W+1:0]  trial;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!trial[DSR_W+1]) begin
        rem_r <= trial[DSR_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DSR_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quo  = q_r;
  assign rem  = rem_r;
  assign busy = busy_r;
  assign done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

// ===== hdl/sspc_dp.sv =====
// ----------------------------------------------------------------------------
// sspc_dp
// Datapath: configuration, motion state, position and rate arithmetic.
// ----------------------------------------------------------------------------
module sspc_dp import sspc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_op_t           op,
  output dp_sts_t          sts,
  input  logic [63:0]      in_tdata,
  input  logic [2:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  logic signed [31:0] minp_r, maxp_r, startp_r;
  logic [30:0]        mins_r, maxs_r, ss_r;
  logic               wrap_r;

  logic signed [31:0] cnt_r, prev_r, cur_r, s_r, ip_r, meas_r, cmd_r;
  logic [1:0]         dir_r;
  logic [31:0]        freq_r, dt_r;
  logic [2:0]         req_r;
  logic signed [63:0] p_r;
  logic               wneg_r, sgn_r, stat_r, dflag_r, fflag_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic signed [32:0] range33;
  logic               range_bad;
  logic signed [64:0] pd65;
  logic [63:0]        pd_mag;
  logic signed [32:0] iwd33;
  logic [32:0]        iwd_mag;
  logic [32:0]        r33;
  logic [32:0]        wres33;
  logic signed [31:0] tgt;
  logic signed [32:0] diff33;
  logic [32:0]        diff_mag;
  logic [31:0]        ip_mag;
  logic [33:0]        idnd;
  logic [31:0]        a32;
  logic [30:0]        ac;
  logic               stop;
  logic [1:0]         dir_new;
  logic [31:0]        qsat;
  logic               div_start, div_busy, div_done;
  logic [DIV_W-1:0]   div_dnd, div_quo;
  logic [DSR_W-1:0]   div_dsr, div_rem;

  assign range33   = {maxp_r[31], maxp_r} - {minp_r[31], minp_r};
  assign range_bad = (maxp_r <= minp_r);

  assign pd65   = {p_r[63], p_r} - {{33{minp_r[31]}}, minp_r};
  assign pd_mag = pd65[64] ? 64'(-pd65) : pd65[63:0];
  assign iwd33  = {ip_r[31], ip_r} - {minp_r[31], minp_r};
  assign iwd_mag = iwd33[32] ? 33'(-iwd33) : iwd33;

  assign r33    = wneg_r ? ((div_rem == '0) ? '0 : 33'(range33) - div_rem) : div_rem;
  assign wres33 = {minp_r[31], minp_r} + r33;

  always_comb begin
    if (cmd_r < minp_r)      tgt = minp_r;
    else if (cmd_r > maxp_r) tgt = maxp_r;
    else                     tgt = cmd_r;
  end

  assign diff33   = (req_r == REQ_SETPOS) ? ({tgt[31], tgt} - {cur_r[31], cur_r})
                                          : ({cur_r[31], cur_r} - {prev_r[31], prev_r});
  assign diff_mag = diff33[32] ? 33'(-diff33) : diff33;

  assign ip_mag = ip_r[31] ? 32'(-ip_r) : ip_r;
  assign idnd   = {1'b0, ip_mag, 1'b0} + {3'b0, ss_r};

  assign a32     = s_r[31] ? 32'(-s_r) : s_r;
  assign stop    = (a32 == '0) || (a32 < {1'b0, mins_r});
  assign dir_new = stop ? DIR_STOP : (s_r[31] ? DIR_BWD : DIR_FWD);
  assign ac      = (a32 > {1'b0, maxs_r}) ? maxs_r : a32[30:0];
  assign qsat    = sat_q(div_quo, sgn_r);

  always_comb begin
    div_start = 1'b0;
    div_dnd   = '0;
    div_dsr   = range33;
    case (op)
      OP_PDIV_GO: begin
        div_start = 1'b1;
        div_dnd   = pd_mag;
      end
      OP_IWDIV_GO: begin
        div_start = 1'b1;
        div_dnd   = DIV_W'(iwd_mag);
      end
      OP_RDIV_GO: begin
        div_start = 1'b1;
        div_dnd   = {{(DIV_W-33-FRAC_BITS){1'b0}}, diff_mag, {FRAC_BITS{1'b0}}};
        div_dsr   = {1'b0, dt_r};
      end
      OP_SPD: begin
        div_start = !stop && (ss_r != '0);
        div_dnd   = DIV_W'(ac);
        div_dsr   = {2'b0, ss_r};
      end
      OP_IDIV_GO: begin
        div_start = 1'b1;
        div_dnd   = DIV_W'(idnd);
        div_dsr   = {1'b0, ss_r, 1'b0};
      end
      default: begin
      end
    endcase
  end

  sspc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .quo      (div_quo),
    .rem      (div_rem),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minp_r   <= 32'sh8000_0000;
      maxp_r   <= 32'sh7FFF_FFFF;
      mins_r   <= '0;
      maxs_r   <= 31'h7FFF_FFFF;
      ss_r     <= 31'd65536;
      wrap_r   <= 1'b0;
      startp_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_POS:   minp_r   <= cfg_data;
        CFG_MAX_POS:   maxp_r   <= cfg_data;
        CFG_MIN_SPD:   mins_r   <= cfg_data[30:0];
        CFG_MAX_SPD:   maxs_r   <= cfg_data[30:0];
        CFG_STEP_SIZE: ss_r     <= cfg_data[30:0];
        CFG_WRAP_EN:   wrap_r   <= cfg_data[0];
        CFG_START_POS: startp_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      dir_r       <= DIR_STOP;
      freq_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          req_r   <= in_tuser;
          cmd_r   <= in_tdata[31:0];
          dt_r    <= in_tdata[63:32];
          stat_r  <= 1'b0;
          meas_r  <= '0;
          dflag_r <= 1'b0;
          fflag_r <= 1'b0;
        end
        OP_STEP: begin
          if (dir_r == DIR_BWD && cnt_r != 32'sh8000_0000) cnt_r <= cnt_r - 1;
          else if (dir_r == DIR_FWD && cnt_r != 32'sh7FFF_FFFF) cnt_r <= cnt_r + 1;
        end
        OP_RESET: begin
          if (dir_r != DIR_STOP) dflag_r <= 1'b1;
          if (freq_r != '0) fflag_r <= 1'b1;
          dir_r  <= DIR_STOP;
          freq_r <= '0;
          cnt_r  <= '0;
        end
        OP_SETSPD: s_r <= cmd_r;
        OP_BAD:    stat_r <= 1'b1;
        OP_PMUL:   p_r <= cnt_r * $signed({1'b0, ss_r});
        OP_PSAT: begin
          if (p_r[63:31] == '0 || p_r[63:31] == '1) cur_r <= p_r[31:0];
          else cur_r <= p_r[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        OP_PDIV_GO:  wneg_r <= pd65[64];
        OP_PFIX:     cur_r  <= wres33[31:0];
        OP_RDIV_GO:  sgn_r  <= diff33[32];
        OP_RFIX: begin
          if (req_r == REQ_SETPOS) begin
            s_r <= qsat;
          end else begin
            meas_r <= qsat;
            prev_r <= cur_r;
          end
        end
        OP_SPD: begin
          if (dir_new != dir_r) begin
            dir_r   <= dir_new;
            dflag_r <= 1'b1;
          end
          if (!stop && ss_r == '0 && freq_r != '0) begin
            freq_r  <= '0;
            fflag_r <= 1'b1;
          end
        end
        OP_FFIX: begin
          if (div_quo[31:0] != freq_r) begin
            freq_r  <= div_quo[31:0];
            fflag_r <= 1'b1;
          end
        end
        OP_INIT: begin
          dir_r  <= DIR_STOP;
          freq_r <= '0;
          prev_r <= '0;
          cnt_r  <= '0;
          ip_r   <= startp_r;
        end
        OP_IWDIV_GO: wneg_r <= iwd33[32];
        OP_IWFIX:    ip_r   <= wres33[31:0];
        OP_IDIV_GO:  sgn_r  <= ip_r[31];
        OP_IFIX:     cnt_r  <= qsat;
        OP_OUT: begin
          out_data_r <= {3'b0, meas_r, cur_r, fflag_r, dflag_r, freq_r, dir_r, stat_r};
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.req       = req_r;
  assign sts.dt_zero   = (dt_r == '0);
  assign sts.ss_zero   = (ss_r == '0);
  assign sts.wrap_en   = wrap_r;
  assign sts.range_bad = range_bad;
  assign sts.spd_stop  = stop;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("division issued while divider busy");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    dir_r != 2'd3)
    else $error("direction register holds an unused code");

endmodule

// ===== hdl/sspc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sspc_ctrl
// Request sequencer: issues one datapath operation per cycle, or none while it waits for the divider or the output.
// ----------------------------------------------------------------------------
module sspc_ctrl import sspc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_op_t  op
);

  ctrl_st_t st_r, st_nxt;
  logic     fin_r, fin_nxt;
  logic     wrap_go, pos_bad;

  assign wrap_go = sts.wrap_en && !sts.ss_zero && !sts.range_bad;
  assign pos_bad = sts.wrap_en && !sts.ss_zero && sts.range_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      fin_r <= 1'b1;
    end else begin
      st_r  <= st_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    fin_nxt = fin_r;
    unique case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = ST_DISP;
      ST_DISP: begin
        fin_nxt = 1'b1;
        case (sts.req)
          REQ_SETSPD: st_nxt = ST_SPD;
          REQ_SETPOS, REQ_MEAS: begin
            fin_nxt = sts.dt_zero;
            st_nxt  = ST_PMUL;
          end
          REQ_INIT: st_nxt = ST_INIT_CHK;
          default:  st_nxt = ST_PMUL;
        endcase
      end
      ST_INIT_CHK: begin
        priority if (sts.ss_zero)     st_nxt = ST_PMUL;
        else if (sts.wrap_en)         st_nxt = sts.range_bad ? ST_PMUL : ST_IWDIV;
        else                          st_nxt = ST_IDIV;
      end
      ST_PMUL:  st_nxt = ST_PWRAP;
      ST_PWRAP: st_nxt = wrap_go ? ST_PDIV : (fin_r ? ST_OUT : ST_PRE);
      ST_PDIV:  if (sts.div_done) st_nxt = fin_r ? ST_OUT : ST_PRE;
      ST_PRE: begin
        if (pos_bad) begin
          fin_nxt = 1'b1;
          st_nxt  = ST_PMUL;
        end else begin
          st_nxt = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (sts.div_done) begin
          fin_nxt = 1'b1;
          st_nxt  = (sts.req == REQ_SETPOS) ? ST_SPD : ST_PMUL;
        end
      end
      ST_SPD:     st_nxt = (sts.spd_stop || sts.ss_zero) ? ST_PMUL : ST_FDIV;
      ST_FDIV:    if (sts.div_done) st_nxt = ST_PMUL;
      ST_IWDIV:   if (sts.div_done) st_nxt = ST_IDIV_GO;
      ST_IDIV_GO: st_nxt = ST_IDIV;
      ST_IDIV:    if (sts.div_done) st_nxt = ST_PMUL;
      ST_OUT:     if (sts.out_free) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    unique case (st_r)
      ST_IDLE: if (in_tvalid) op = OP_LOAD;
      ST_DISP: begin
        case (sts.req)
          REQ_STEP:             op = OP_STEP;
          REQ_RESET:            op = OP_RESET;
          REQ_SETSPD:           op = OP_SETSPD;
          REQ_SETPOS, REQ_MEAS: op = sts.dt_zero ? OP_BAD : OP_NONE;
          REQ_INIT:             op = OP_INIT;
          default:              op = OP_NONE;
        endcase
      end
      ST_INIT_CHK: begin
        priority if (sts.ss_zero)     op = OP_NONE;
        else if (sts.wrap_en)         op = sts.range_bad ? OP_BAD : OP_IWDIV_GO;
        else                          op = OP_IDIV_GO;
      end
      ST_PMUL:    op = OP_PMUL;
      ST_PWRAP:   op = wrap_go ? OP_PDIV_GO : OP_PSAT;
      ST_PDIV:    if (sts.div_done) op = OP_PFIX;
      ST_PRE:     op = pos_bad ? OP_BAD : OP_RDIV_GO;
      ST_RDIV:    if (sts.div_done) op = OP_RFIX;
      ST_SPD:     op = OP_SPD;
      ST_FDIV:    if (sts.div_done) op = OP_FFIX;
      ST_IWDIV:   if (sts.div_done) op = OP_IWFIX;
      ST_IDIV_GO: op = OP_IDIV_GO;
      ST_IDIV:    if (sts.div_done) op = OP_IFIX;
      ST_OUT:     if (sts.out_free) op = OP_OUT;
      default:    op = OP_NONE;
    endcase
  end

  assign in_tready = (st_r == ST_IDLE);

  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && sts.out_free) |=> st_r == ST_IDLE)
    else $error("result transfer did not release the sequencer");

endmodule

// ===== hdl/stepper_speed_position_controller.sv =====
// ----------------------------------------------------------------------------
// stepper_speed_position_controller
// Divisions run one at a time on the one shared 64-step divider.
// Requests are handled one at a time; the next transfer is taken the cycle
// after the result is loaded.
// Reset: synchronous rst_n clears motion state and reloads register defaults.
// ----------------------------------------------------------------------------
module stepper_speed_position_controller import sspc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // command_value, interval
  input  logic [2:0]       in_tuser,   // req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // status, direction, step_frequency,
                                       // direction_update, frequency_update,
                                       // position, measured_speed
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  dp_op_t  op;
  dp_sts_t sts;

  sspc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .op        (op)
  );

  sspc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  assign cfg_ready = 1'b1;

endmodule

// ===== test/tb_stepper_speed_position_controller.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_speed_position_controller
// Self-checking bench for the stepper speed/position controller. A built-in
// Q16.16 predictor tracks step count, direction, frequency and the previous
// position; every request result is compared field by field with it. Runs
// directed cases (extremes, saturation, wrapping, invalid ranges) and then
// random phases under changing register settings and random stalls.
// ----------------------------------------------------------------------------
module tb_stepper_speed_position_controller import sspc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam longint     CYCLE_LIMIT = 3000000;
  localparam logic [63:0] TOP64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        status;
    logic [1:0]  direction;
    logic [31:0] step_frequency;
    logic        direction_update;
    logic        frequency_update;
    logic [31:0] position;
    logic [31:0] measured_speed;
  } motor_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  stepper_speed_position_controller dut (.*);

  always #5 clk = ~clk;

  // register mirror and motor state
  longint      pos_lo, pos_hi, pos_start;
  logic [63:0] spd_lo, spd_hi, step_sz;
  logic        wrap_on;
  longint      steps;
  logic [1:0]  motion;
  logic [31:0] freq;
  longint      last_pos;
  logic        dir_chg, freq_chg;

  motor_result_t expected_q[$];
  bit  failed = 0;
  bit  quiet = 0;
  longint cycles = 0;
  int  stall_left = 0;

  function automatic logic [63:0] mag64(longint v);
    logic [63:0] r;
    r = v;
    if (v < 0) r = -r;
    return r;
  endfunction

  function automatic longint with_sign(logic [63:0] m, logic neg);
    if (!neg) return longint'(m);
    if (m >= TOP64) return longint'(TOP64);
    return -longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] mod_pos(longint v, logic [63:0] r);
    logic [63:0] m;
    if (v >= 0) return unsigned'(v) % r;
    m = mag64(v) % r;
    return (m != 0) ? r - m : 64'd0;
  endfunction

  function automatic longint wrap_into_range(longint p, output logic ok);
    logic [63:0] span, pm, mm, r;
    ok = 1'b1;
    if (pos_hi <= pos_lo) begin
      ok = 1'b0;
      return p;
    end
    span = pos_hi - pos_lo;
    pm = mod_pos(p, span);
    mm = mod_pos(pos_lo, span);
    r = (pm >= mm) ? pm - mm : pm + span - mm;
    return pos_lo + longint'(r);
  endfunction

  function automatic longint position_of(longint cnt, output logic ok);
    logic [63:0] m, lim, prod;
    logic neg;
    longint p;
    ok = 1'b1;
    if (step_sz == 0) return 0;
    neg = cnt < 0;
    m = mag64(cnt);
    lim = neg ? TOP64 : TOP64 - 1;
    prod = (m > lim / step_sz) ? lim : m * step_sz;
    p = with_sign(prod, neg);
    if (wrap_on) p = wrap_into_range(p, ok);
    return clamp32(p);
  endfunction

  function automatic longint rate_q16(longint diff, logic [31:0] dt);
    logic [63:0] q;
    q = (mag64(diff) << FRAC_BITS) / {32'd0, dt};
    if (diff < 0) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic longint clamp_count(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic command_speed(longint s);
    logic [63:0] a;
    logic [1:0] d;
    logic [31:0] f;
    a = mag64(s);
    if (a == 0 || a < spd_lo) d = DIR_STOP;
    else d = (s > 0) ? DIR_FWD : DIR_BWD;
    if (d != motion) begin
      motion = d;
      dir_chg = 1'b1;
    end
    if (d != DIR_STOP) begin
      if (a > spd_hi) a = spd_hi;
      f = (step_sz == 0) ? 32'd0 : 32'(a / step_sz);
      if (f != freq) begin
        freq = f;
        freq_chg = 1'b1;
      end
    end
  endtask

  task automatic predict_motor(logic [2:0] req, logic [31:0] cmd_bits, logic [31:0] dt);
    motor_result_t r;
    longint cmd, cur, tgt, p, meas;
    logic ok;
    logic st;
    cmd = longint'(signed'(cmd_bits));
    meas = 0;
    st = 1'b0;
    dir_chg = 1'b0;
    freq_chg = 1'b0;
    case (req)
      REQ_STEP: begin
        if (motion == DIR_BWD) steps = clamp_count(steps - 1);
        else if (motion == DIR_FWD) steps = clamp_count(steps + 1);
      end
      REQ_SETSPD: command_speed(cmd);
      REQ_SETPOS: begin
        if (dt == 0) st = 1'b1;
        else begin
          cur = position_of(steps, ok);
          if (!ok) st = 1'b1;
          else begin
            tgt = cmd;
            if (tgt < pos_lo) tgt = pos_lo;
            else if (tgt > pos_hi) tgt = pos_hi;
            command_speed(rate_q16(tgt - cur, dt));
          end
        end
      end
      REQ_MEAS: begin
        if (dt == 0) st = 1'b1;
        else begin
          cur = position_of(steps, ok);
          if (!ok) st = 1'b1;
          else begin
            meas = rate_q16(cur - last_pos, dt);
            last_pos = cur;
          end
        end
      end
      REQ_INIT: begin
        p = pos_start;
        motion = DIR_STOP;
        freq = '0;
        last_pos = 0;
        steps = 0;
        if (step_sz != 0) begin
          ok = 1'b1;
          if (wrap_on) p = wrap_into_range(p, ok);
          if (!ok) st = 1'b1;
          else steps = clamp_count(with_sign((2 * mag64(p) + step_sz) / (2 * step_sz), p < 0));
        end
      end
      REQ_RESET: begin
        if (motion != DIR_STOP) begin
          motion = DIR_STOP;
          dir_chg = 1'b1;
        end
        if (freq != 0) begin
          freq = '0;
          freq_chg = 1'b1;
        end
        steps = 0;
      end
      default: ;
    endcase
    cur = position_of(steps, ok);
    r.status = st;
    r.direction = motion;
    r.step_frequency = freq;
    r.direction_update = dir_chg;
    r.frequency_update = freq_chg;
    r.position = cur[31:0];
    r.measured_speed = meas[31:0];
    expected_q.push_back(r);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    motor_result_t got, exp_r;
    if (out_tvalid && out_tready) begin
      got = '{status: out_tdata[0], direction: out_tdata[2:1],
              step_frequency: out_tdata[34:3], direction_update: out_tdata[35],
              frequency_update: out_tdata[36], position: out_tdata[68:37],
              measured_speed: out_tdata[100:69]};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        failed = 1;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_r.status, got.status);
          failed = 1;
        end
        if (got.direction !== exp_r.direction) begin
          $display("%0t direction: expected %0d actual %0d", $time,
                   exp_r.direction, got.direction);
          failed = 1;
        end
        if (got.step_frequency !== exp_r.step_frequency) begin
          $display("%0t step_frequency: expected %0d actual %0d", $time,
                   exp_r.step_frequency, got.step_frequency);
          failed = 1;
        end
        if (got.direction_update !== exp_r.direction_update) begin
          $display("%0t direction_update: expected %0d actual %0d", $time,
                   exp_r.direction_update, got.direction_update);
          failed = 1;
        end
        if (got.frequency_update !== exp_r.frequency_update) begin
          $display("%0t frequency_update: expected %0d actual %0d", $time,
                   exp_r.frequency_update, got.frequency_update);
          failed = 1;
        end
        if (got.position !== exp_r.position) begin
          $display("%0t position: expected %h actual %h", $time,
                   exp_r.position, got.position);
          failed = 1;
        end
        if (got.measured_speed !== exp_r.measured_speed) begin
          $display("%0t measured_speed: expected %h actual %h", $time,
                   exp_r.measured_speed, got.measured_speed);
          failed = 1;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && !quiet && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] req, logic [31:0] cmd, logic [31:0] dt);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {dt, cmd};
    do @(posedge clk); while (!in_tready);
    predict_motor(req, cmd, dt);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_registers(logic [31:0] lo, logic [31:0] hi, logic [30:0] slo,
                                 logic [30:0] shi, logic [30:0] ss, logic wr,
                                 logic [31:0] start);
    logic [31:0] vals[7];
    logic [2:0] idx[7];
    vals = '{lo, hi, {1'b0, slo}, {1'b0, shi}, {1'b0, ss}, {31'd0, wr}, start};
    idx = '{CFG_MIN_POS, CFG_MAX_POS, CFG_MIN_SPD, CFG_MAX_SPD, CFG_STEP_SIZE,
            CFG_WRAP_EN, CFG_START_POS};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    pos_lo = longint'(signed'(lo));
    pos_hi = longint'(signed'(hi));
    spd_lo = {33'd0, slo};
    spd_hi = {33'd0, shi};
    step_sz = {33'd0, ss};
    wrap_on = wr;
    pos_start = longint'(signed'(start));
  endtask

  task automatic test_basic_requests;
    send_request(REQ_STEP, 32'd0, 32'd0);
    send_request(REQ_SETSPD, 32'd0, 32'd0);
    send_request(REQ_SETSPD, 32'h0002_8000, 32'd0);
    send_request(REQ_STEP, 32'd0, 32'd0);
    send_request(REQ_STEP, 32'd0, 32'd0);
    send_request(REQ_SETSPD, 32'h8000_0000, 32'd0);
    send_request(REQ_STEP, 32'd0, 32'd0);
    send_request(REQ_MEAS, 32'd0, 32'd0);
    send_request(REQ_MEAS, 32'd0, 32'd1);
    send_request(REQ_MEAS, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_SETPOS, 32'h7FFF_FFFF, 32'd0);
    send_request(REQ_SETPOS, 32'h7FFF_FFFF, 32'd1);
    send_request(REQ_SETPOS, 32'h0000_0000, 32'h0001_0000);
    send_request(REQ_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_B, 32'd0, 32'd0);
    send_request(REQ_RESET, 32'd0, 32'd0);
    send_request(REQ_INIT, 32'd0, 32'd0);
  endtask

  task automatic test_count_saturation;
    write_registers(32'h8000_0000, 32'h7FFF_FFFF, 31'd5, 31'h7FFF_FFFF, 31'd1, 1'b0,
                    32'h7FFF_FFFF);
    send_request(REQ_INIT, 32'd0, 32'd0);
    send_request(REQ_SETSPD, 32'h0000_0003, 32'd0);
    send_request(REQ_SETSPD, 32'h7FFF_FFFF, 32'd0);
    send_request(REQ_STEP, 32'd0, 32'd0);
    send_request(REQ_MEAS, 32'd0, 32'd1);
    write_registers(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'd0, 31'h7FFF_FFFF, 1'b0,
                    32'h8000_0000);
    send_request(REQ_INIT, 32'd0, 32'd0);
    send_request(REQ_SETSPD, 32'hFFFF_0000, 32'd0);
    send_request(REQ_STEP, 32'd0, 32'd0);
    send_request(REQ_SETPOS, 32'h7FFF_FFFF, 32'd1);
  endtask

  task automatic test_wrap_and_bad_range;
    write_registers(32'h0001_0000, 32'h0005_0000, 31'd0, 31'h7FFF_FFFF, 31'h1_0000, 1'b1,
                    32'hFFFA_0000);
    send_request(REQ_INIT, 32'd0, 32'd0);
    send_request(REQ_SETPOS, 32'h0009_0000, 32'h0000_8000);
    send_request(REQ_STEP, 32'd0, 32'd0);
    send_request(REQ_MEAS, 32'd0, 32'h0001_0000);
    write_registers(32'h0003_0000, 32'h0003_0000, 31'd0, 31'h7FFF_FFFF, 31'h1_0000, 1'b1,
                    32'h0002_0000);
    send_request(REQ_SETPOS, 32'h0001_0000, 32'h0001_0000);
    send_request(REQ_MEAS, 32'd0, 32'h0001_0000);
    send_request(REQ_INIT, 32'd0, 32'd0);
    write_registers(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 31'd0, 1'b0,
                    32'h0001_0000);
    send_request(REQ_SETSPD, 32'h0004_0000, 32'd0);
    send_request(REQ_INIT, 32'd0, 32'd0);
    send_request(REQ_SETPOS, 32'h0004_0000, 32'h0001_0000);
  endtask

  function automatic logic [31:0] pick_value(logic [30:0] ss);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 8) * ss + $urandom_range(0, 3);
      2: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: v = $urandom_range(0, 32'h000F_FFFF);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic test_random_traffic;
    logic [31:0] a, b, dt;
    logic [30:0] ss;
    logic [2:0] req;
    for (int ph = 0; ph < 16; ph++) begin
      a = $urandom;
      b = $urandom;
      if ($urandom_range(0, 7) == 0) b = a;
      else if ($signed(a) > $signed(b)) {a, b} = {b, a};
      case ($urandom_range(0, 4))
        0: ss = 31'd0;
        1: ss = 31'd1;
        2: ss = 31'h7FFF_FFFF;
        default: ss = 31'h1_0000 >> $urandom_range(0, 16);
      endcase
      if (ss == 0 && $urandom_range(0, 1)) ss = 31'($urandom);
      write_registers(a, b, 31'($urandom_range(0, 31'h0002_0000)),
                      $urandom_range(0, 3) == 0 ? 31'h7FFF_FFFF : 31'($urandom),
                      ss, 1'($urandom_range(0, 1)), $urandom);
      for (int i = 0; i < 100; i++) begin
        if (ph == 15 && i == 10) quiet = 1;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: req = REQ_STEP;
          7, 8, 9: req = REQ_SETSPD;
          10, 11, 12: req = REQ_SETPOS;
          13, 14, 15: req = REQ_MEAS;
          16: req = REQ_INIT;
          17: req = REQ_RESET;
          default: req = 3'($urandom_range(0, 7));
        endcase
        case ($urandom_range(0, 9))
          0: dt = 32'd0;
          1, 2, 3: dt = $urandom;
          default: dt = $urandom_range(1, 32'h0004_0000);
        endcase
        send_request(req, pick_value(ss), dt);
      end
    end
  endtask

  initial begin
    pos_lo = -64'sd2147483648;
    pos_hi = 64'sd2147483647;
    spd_lo = 0;
    spd_hi = 64'h7FFF_FFFF;
    step_sz = 64'd65536;
    wrap_on = 1'b0;
    pos_start = 0;
    steps = 0;
    motion = DIR_STOP;
    freq = '0;
    last_pos = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_requests();
    test_count_saturation();
    test_wrap_and_bad_range();
    test_random_traffic();
    drain();
    repeat (300) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sspc_pkg.sv
hdl/sspc_div.sv
hdl/sspc_dp.sv
hdl/sspc_ctrl.sv
hdl/stepper_speed_position_controller.sv
test/tb_stepper_speed_position_controller.sv
